// ===== rtl/assert_macros.svh =====
// Assertion macros of the offset-transition block, used by signal_offset_transition.
// Needs a clock i_clk and an active-low reset i_rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SOT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define SOT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/sot_pkg.sv =====
// Package of the signal offset-transition block: sizes, codes, payload types
// and small helper functions. Used by sot_div and signal_offset_transition.
package sot_pkg;

    localparam int PHASES      = 16;
    localparam int RINGS       = 4;
    localparam int MAX_CYCLE   = 255;
    localparam int SHORT_LIMIT = 5;

    localparam int PH_W    = $clog2(PHASES);
    localparam int RING_AW = (RINGS > 1) ? $clog2(RINGS) : 1;
    localparam int SEQ_AW  = RING_AW + PH_W;
    localparam int CONC_AW = 2 * PH_W;
    localparam int CLR_W   = (CONC_AW > SEQ_AW) ? CONC_AW : SEQ_AW;
    localparam int SUM_W   = PH_W + 8;
    localparam int BEG_W   = SUM_W + 2;
    localparam int DIV_NW  = 17;
    localparam int DIV_DW  = 8;

    typedef enum logic [2:0] {
        OP_SEQ   = 3'd0,
        OP_PHASE = 3'd1,
        OP_CONC  = 3'd2,
        OP_CYCLE = 3'd3,
        OP_EVAL  = 3'd4,
        OP_READ  = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        CFG_COORD = 3'd0,
        CFG_OFFS  = 3'd1,
        CFG_TCYC  = 3'd2,
        CFG_CMASK = 3'd3,
        CFG_IMASK = 3'd4
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_DEC, S_RDW, S_OUT,
        S_E_CREC, S_P_SEQ, S_P_PH, S_P_END,
        S_D1, S_D2, S_CORR, S_D3, S_CAP, S_APPLY,
        S_C_LST, S_C_PH, S_R_START, S_S_SEQ, S_S_PH, S_A_RD, S_R_NEXT
    } t_state;

    typedef struct packed {
        logic [2:0]  operation;
        logic [1:0]  ring_index;
        logic [3:0]  position;
        logic [4:0]  phase_id;
        logic [4:0]  entry_phase;
        logic [7:0]  split_value;
        logic [7:0]  green_value;
        logic [2:0]  phase_ring;
        logic [7:0]  cycle_value;
        logic [16:0] time_gap;
    } t_req;

    typedef struct packed {
        logic signed [8:0] transition_time;
        logic [7:0]        new_cycle;
        logic [7:0]        read_split;
        logic [7:0]        read_green;
        logic              was_applied;
    } t_res;

    typedef struct packed {
        logic [2:0] ring;
        logic [7:0] green;
        logic [7:0] split;
    } t_prec;

    function automatic logic phase_ok(input logic [4:0] p);
        return (p != 5'd0) && (32'(p) <= PHASES);
    endfunction

    function automatic logic ring_ok(input logic [2:0] r);
        return (r != 3'd0) && (32'(r) <= RINGS);
    endfunction

    function automatic logic [7:0] sat8(input logic signed [10:0] v);
        logic [7:0] res;
        if (v < 0) begin
            res = 8'd0;
        end else if (v > 11'sd255) begin
            res = 8'd255;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/sot_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read. No dependencies.
module sot_ram #(
    parameter int AW = 4,
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/sot_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on sot_pkg for the operand widths.
module sot_div
    import sot_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_dividend,
    input  logic [DIV_DW-1:0] i_divisor,
    output logic              o_done,
    output logic [DIV_NW-1:0] o_quot,
    output logic [DIV_DW-1:0] o_rem
);

    localparam int CNT_W = $clog2(DIV_NW + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_dvs;
    logic [DIV_DW:0]   w_trial;
    logic              w_ge;

    assign w_trial = {r_rem, r_quo[DIV_NW-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_NW-2:0], w_ge};
            r_rem <= w_ge ? DIV_DW'(w_trial - {1'b0, r_dvs}) : w_trial[DIV_DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/signal_offset_transition.sv =====
// A table or cycle write is done in the decode state; a read passes on through the RAM
// read-wait and output states; an evaluation runs table walks (two RAM reads per
// slot) and up to three divisions. One request is in work at a time.
// Reset: synchronous, active low; afterwards a clearing pass zeroes the sequence,
// phase and concurrency RAMs while requests are stalled.
module signal_offset_transition
    import sot_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    output logic        o_req_stall,
    input  t_req        i_req_data,
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output t_res        o_res_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

`include "assert_macros.svh"

    t_state r_state, n_state;
    t_req   r_req;
    logic [CLR_W-1:0] r_cnt, n_cnt;
    logic [7:0] r_cycle, n_cycle, r_cl, n_cl;
    logic [4:0] r_coord;
    logic [7:0] r_soff, r_tcyc;
    logic [15:0] r_cmask, r_imask;
    logic [2:0] r_cring, n_cring;
    logic [7:0] r_csplit, n_csplit;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [PH_W-1:0] r_idx, n_idx;
    logic [4:0] r_p, n_p;
    logic signed [BEG_W-1:0] r_begin, n_begin, r_offset, n_offset;
    logic [7:0] r_gmod, n_gmod;
    logic signed [9:0] r_excess, n_excess, r_t, n_t;
    logic r_applied, n_applied;
    logic [7:0] r_rsplit, n_rsplit, r_rgreen, n_rgreen;
    logic [4:0] r_chosen [RINGS];
    logic [4:0] n_chosen [RINGS];
    logic [RING_AW-1:0] r_ring, n_ring;
    logic r_res_vld;
    t_res r_res, n_res;
    logic w_res_load;

    logic seq_we, ph_we, cc_we;
    logic [SEQ_AW-1:0] seq_wa, seq_ra;
    logic [PH_W-1:0] ph_wa, ph_ra;
    logic [CONC_AW-1:0] cc_wa, cc_ra;
    logic [4:0] seq_wd, seq_rd, cc_wd, cc_rd;
    t_prec ph_wd, ph_rd;
    logic [$bits(t_prec)-1:0] ph_rd_raw;

    logic w_div_start, w_div_done;
    logic [DIV_NW-1:0] w_div_a, w_div_q;
    logic [DIV_DW-1:0] w_div_b, w_div_r;

    sot_ram #(.AW(SEQ_AW), .DW(5)) u_seq (
        .i_clk(i_clk), .i_we(seq_we), .i_waddr(seq_wa), .i_wdata(seq_wd),
        .i_raddr(seq_ra), .o_rdata(seq_rd)
    );
    sot_ram #(.AW(PH_W), .DW($bits(t_prec))) u_phase (
        .i_clk(i_clk), .i_we(ph_we), .i_waddr(ph_wa), .i_wdata(ph_wd),
        .i_raddr(ph_ra), .o_rdata(ph_rd_raw)
    );
    sot_ram #(.AW(CONC_AW), .DW(5)) u_conc (
        .i_clk(i_clk), .i_we(cc_we), .i_waddr(cc_wa), .i_wdata(cc_wd),
        .i_raddr(cc_ra), .o_rdata(cc_rd)
    );
    sot_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_dividend(w_div_a), .i_divisor(w_div_b), .o_done(w_div_done),
        .o_quot(w_div_q), .o_rem(w_div_r)
    );

    assign ph_rd = t_prec'(ph_rd_raw);
    assign o_req_stall = (r_state != S_IDLE);
    assign o_res_valid = r_res_vld;
    assign o_res_data  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coord <= '0;
            r_soff  <= '0;
            r_tcyc  <= '0;
            r_cmask <= '0;
            r_imask <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COORD: r_coord <= i_cfg_data[4:0];
                CFG_OFFS:  r_soff  <= i_cfg_data[7:0];
                CFG_TCYC:  r_tcyc  <= i_cfg_data[7:0];
                CFG_CMASK: r_cmask <= i_cfg_data;
                CFG_IMASK: r_imask <= i_cfg_data;
                default:   r_coord <= r_coord;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_cnt     <= '0;
            r_cycle   <= '0;
            r_cl      <= '0;
            r_res_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_cycle <= n_cycle;
            r_cl    <= n_cl;
            if (w_res_load) begin
                r_res_vld <= 1'b1;
            end else if (!i_res_stall) begin
                r_res_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req_valid && !o_req_stall) begin
            r_req <= i_req_data;
        end
        r_cring   <= n_cring;
        r_csplit  <= n_csplit;
        r_sum     <= n_sum;
        r_idx     <= n_idx;
        r_p       <= n_p;
        r_begin   <= n_begin;
        r_offset  <= n_offset;
        r_gmod    <= n_gmod;
        r_excess  <= n_excess;
        r_t       <= n_t;
        r_applied <= n_applied;
        r_rsplit  <= n_rsplit;
        r_rgreen  <= n_rgreen;
        r_chosen  <= n_chosen;
        r_ring    <= n_ring;
        r_res     <= n_res;
    end

    logic [PH_W-1:0] w_cidx, w_pidx;
    logic signed [BEG_W-1:0] w_begin, w_offs;
    logic signed [9:0] w_ofmod, w_total, w_cl_s;
    logic [7:0] w_cl_eff;
    logic [RING_AW-1:0] w_rsel;
    logic signed [10:0] w_sum_t;

    always_comb begin
        n_state = r_state;  n_cnt = r_cnt;  n_cycle = r_cycle;  n_cl = r_cl;
        n_cring = r_cring;  n_csplit = r_csplit;  n_sum = r_sum;  n_idx = r_idx;
        n_p = r_p;  n_begin = r_begin;  n_offset = r_offset;  n_gmod = r_gmod;
        n_excess = r_excess;  n_t = r_t;  n_applied = r_applied;
        n_rsplit = r_rsplit;  n_rgreen = r_rgreen;  n_chosen = r_chosen;
        n_ring = r_ring;  n_res = r_res;
        w_res_load = 1'b0;
        seq_we = 1'b0;  seq_wa = '0;  seq_wd = '0;  seq_ra = '0;
        ph_we = 1'b0;   ph_wa = '0;   ph_wd = '0;   ph_ra = '0;
        cc_we = 1'b0;   cc_wa = '0;   cc_wd = '0;   cc_ra = '0;
        w_div_start = 1'b0;  w_div_a = '0;  w_div_b = '0;
        w_cidx = PH_W'(r_coord - 5'd1);
        w_pidx = PH_W'(r_p - 5'd1);
        w_begin = $signed({2'b00, r_sum}) - $signed(BEG_W'(r_csplit));
        w_offs = $signed(BEG_W'(r_soff));
        w_ofmod = r_offset < 0 ? -$signed(10'(w_div_r)) : $signed(10'(w_div_r));
        w_total = r_excess > 0 ? $signed(10'(r_cycle)) - r_excess : -r_excess;
        w_cl_eff = (r_cl != 8'd0) ? r_cl : ((r_tcyc == 8'd0) ? 8'd1 : r_tcyc);
        w_cl_s = $signed(10'(w_cl_eff));
        w_rsel = RING_AW'(ph_rd.ring - 3'd1);
        w_sum_t = $signed(11'(r_cycle)) + 11'(r_t);

        case (r_state)
            S_CLR: begin
                seq_we = 1'b1;  seq_wa = SEQ_AW'(r_cnt);
                ph_we  = 1'b1;  ph_wa  = PH_W'(r_cnt);
                cc_we  = 1'b1;  cc_wa  = CONC_AW'(r_cnt);
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_IDLE;
                n_t = '0;
                n_applied = 1'b0;
                n_rsplit = '0;
                n_rgreen = '0;
                case (r_req.operation)
                    OP_SEQ: begin
                        if (32'(r_req.ring_index) < RINGS) begin
                            seq_we = 1'b1;
                            seq_wa = {RING_AW'(r_req.ring_index), PH_W'(r_req.position)};
                            seq_wd = r_req.entry_phase;
                        end
                    end
                    OP_PHASE: begin
                        if (phase_ok(r_req.phase_id)) begin
                            ph_we = 1'b1;
                            ph_wa = PH_W'(r_req.phase_id - 5'd1);
                            ph_wd = '{ring: r_req.phase_ring, green: r_req.green_value,
                                      split: r_req.split_value};
                        end
                    end
                    OP_CONC: begin
                        if (phase_ok(r_req.phase_id)) begin
                            cc_we = 1'b1;
                            cc_wa = {PH_W'(r_req.phase_id - 5'd1), PH_W'(r_req.position)};
                            cc_wd = r_req.entry_phase;
                        end
                    end
                    OP_CYCLE: n_cycle = r_req.cycle_value;
                    OP_READ: begin
                        if (phase_ok(r_req.phase_id)) begin
                            ph_ra = PH_W'(r_req.phase_id - 5'd1);
                            n_state = S_RDW;
                        end else begin
                            n_state = S_OUT;
                        end
                    end
                    OP_EVAL: begin
                        if (phase_ok(r_coord)) begin
                            ph_ra = w_cidx;
                            n_state = S_E_CREC;
                        end else begin
                            n_state = S_OUT;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_RDW: begin
                n_rsplit = ph_rd.split;
                n_rgreen = ph_rd.green;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_res_vld || !i_res_stall) begin
                    w_res_load = 1'b1;
                    n_res.transition_time = r_t[8:0];
                    n_res.new_cycle = r_cycle;
                    n_res.read_split = r_rsplit;
                    n_res.read_green = r_rgreen;
                    n_res.was_applied = r_applied;
                    n_state = S_IDLE;
                end
            end
            S_E_CREC: begin
                n_cring = ph_rd.ring;
                n_csplit = ph_rd.split;
                n_sum = '0;
                n_idx = '0;
                if (ring_ok(ph_rd.ring)) begin
                    seq_ra = {w_rsel, PH_W'(0)};
                    n_state = S_P_SEQ;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_P_SEQ: begin
                if (phase_ok(seq_rd)) begin
                    n_p = seq_rd;
                    ph_ra = PH_W'(seq_rd - 5'd1);
                    n_state = S_P_PH;
                end else begin
                    n_state = S_P_END;
                end
            end
            S_P_PH: begin
                n_sum = r_sum + SUM_W'(ph_rd.split);
                if (r_p == r_coord || r_idx == PH_W'(PHASES - 1)) begin
                    n_state = S_P_END;
                end else begin
                    n_idx = r_idx + 1'b1;
                    seq_ra = {RING_AW'(r_cring - 3'd1), r_idx + 1'b1};
                    n_state = S_P_SEQ;
                end
            end
            S_P_END: begin
                if (r_sum == '0 || r_imask[w_cidx]) begin
                    n_state = S_OUT;
                end else begin
                    n_applied = 1'b1;
                    n_begin = w_begin;
                    if (w_begin > 0) begin
                        w_offs = w_offs + $signed(BEG_W'(r_cycle)) - w_begin;
                    end
                    n_offset = w_offs;
                    if (r_cycle == 8'd0) begin
                        n_state = S_OUT;
                    end else begin
                        w_div_start = 1'b1;
                        w_div_a = r_req.time_gap;
                        w_div_b = r_cycle;
                        n_state = S_D1;
                    end
                end
            end
            S_D1: begin
                if (w_div_done) begin
                    n_gmod = w_div_r;
                    w_div_start = 1'b1;
                    w_div_a = DIV_NW'(r_offset < 0 ? -r_offset : r_offset);
                    w_div_b = r_cycle;
                    n_state = S_D2;
                end
            end
            S_D2: begin
                if (w_div_done) begin
                    n_excess = $signed(10'(r_gmod)) - w_ofmod;
                    n_state = S_CORR;
                end
            end
            S_CORR: begin
                n_state = S_CAP;
                if (r_excess == 10'sd0 || r_excess == 10'sd1) begin
                    n_cl = '0;
                    n_t = '0;
                end else if (r_excess > 10'sd1 && r_excess <= 10'(SHORT_LIMIT)) begin
                    n_cl = '0;
                    n_t = -r_excess;
                end else begin
                    n_cl = w_cl_eff - 8'd1;
                    if (w_total <= w_cl_s || w_total <= 10'(SHORT_LIMIT)) begin
                        n_t = w_total;
                    end else begin
                        w_div_start = 1'b1;
                        w_div_a = DIV_NW'(w_total);
                        w_div_b = w_cl_eff;
                        n_state = S_D3;
                    end
                end
            end
            S_D3: begin
                if (w_div_done) begin
                    n_t = $signed(10'(w_div_q[7:0]));
                    n_state = S_CAP;
                end
            end
            S_CAP: begin
                if (w_sum_t > 11'(MAX_CYCLE)) begin
                    n_t = 10'(MAX_CYCLE) - $signed(10'(r_cycle));
                    n_cl = r_cl + 8'd1;
                end
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (r_t == 10'sd0) begin
                    n_state = S_OUT;
                end else begin
                    n_cycle = sat8(w_sum_t);
                    for (int i = 0; i < RINGS; i++) begin
                        n_chosen[i] = '0;
                    end
                    n_chosen[RING_AW'(r_cring - 3'd1)] = r_coord;
                    n_idx = '0;
                    cc_ra = {w_cidx, PH_W'(0)};
                    n_state = S_C_LST;
                end
            end
            S_C_LST: begin
                n_ring = '0;
                if (phase_ok(cc_rd)) begin
                    n_p = cc_rd;
                    ph_ra = PH_W'(cc_rd - 5'd1);
                    n_state = S_C_PH;
                end else begin
                    n_state = S_R_START;
                end
            end
            S_C_PH: begin
                if (r_cmask[w_pidx] && ring_ok(ph_rd.ring)) begin
                    n_chosen[w_rsel] = r_p;
                end
                if (r_idx == PH_W'(PHASES - 1)) begin
                    n_state = S_R_START;
                end else begin
                    n_idx = r_idx + 1'b1;
                    cc_ra = {w_cidx, r_idx + 1'b1};
                    n_state = S_C_LST;
                end
            end
            S_R_START: begin
                n_sum = '0;
                n_idx = '0;
                if (r_chosen[r_ring] != 5'd0) begin
                    n_p = r_chosen[r_ring];
                    ph_ra = PH_W'(r_chosen[r_ring] - 5'd1);
                    n_state = S_A_RD;
                end else begin
                    seq_ra = {r_ring, PH_W'(0)};
                    n_state = S_S_SEQ;
                end
            end
            S_S_SEQ: begin
                if (phase_ok(seq_rd)) begin
                    n_p = seq_rd;
                    ph_ra = PH_W'(seq_rd - 5'd1);
                    n_state = S_S_PH;
                end else begin
                    n_state = S_R_NEXT;
                end
            end
            S_S_PH: begin
                n_sum = r_sum + SUM_W'(ph_rd.split);
                if ($signed({2'b00, n_sum}) > r_begin || r_idx == PH_W'(PHASES - 1)) begin
                    ph_ra = w_pidx;
                    n_state = S_A_RD;
                end else begin
                    n_idx = r_idx + 1'b1;
                    seq_ra = {r_ring, r_idx + 1'b1};
                    n_state = S_S_SEQ;
                end
            end
            S_A_RD: begin
                ph_we = 1'b1;
                ph_wa = w_pidx;
                ph_wd.ring = ph_rd.ring;
                ph_wd.split = sat8($signed(11'(ph_rd.split)) + 11'(r_t));
                ph_wd.green = sat8($signed(11'(ph_rd.green)) + 11'(r_t));
                n_state = S_R_NEXT;
            end
            S_R_NEXT: begin
                if (r_ring == RING_AW'(RINGS - 1)) begin
                    n_state = S_OUT;
                end else begin
                    n_ring = r_ring + 1'b1;
                    n_state = S_R_START;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    `SOT_ASSERT_NOW(a_unapplied_zero, o_res_valid,
        o_res_data.was_applied || o_res_data.transition_time == 9'sd0)
    `SOT_ASSERT_NOW(a_div_nonzero, w_div_start, w_div_b != '0)
    `SOT_ASSERT_NEXT(a_clear_stalls, r_state == S_CLR && r_cnt != '1, o_req_stall)

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench of signal_offset_transition: table loads, phase reads and
// offset evaluations against an in-bench predictor, under random idling on both sides.
// Depends on sot_pkg and the signal_offset_transition RTL only.
module testbench;
    import sot_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam int         RUN_LIMIT   = 3000000;
    localparam int         SETTLE      = 300;
    localparam int         LONG_HOLD   = 2000;
    localparam int         REQ_W       = $bits(t_req);

    class offset_scoreboard;
        int   coord, offs, tcyc, cmask, imask;
        int   cycle_time, cycles_left;
        int   seq_tab[RINGS][PHASES];
        int   split_tab[PHASES], green_tab[PHASES], ring_tab[PHASES];
        int   conc_tab[PHASES][PHASES];
        t_res pending[$];
        int   errors;

        function new();
            coord = 0; offs = 0; tcyc = 0; cmask = 0; imask = 0;
            cycle_time = 0; cycles_left = 0; errors = 0;
            foreach (seq_tab[i, j]) seq_tab[i][j] = 0;
            foreach (conc_tab[i, j]) conc_tab[i][j] = 0;
            foreach (split_tab[i]) begin
                split_tab[i] = 0; green_tab[i] = 0; ring_tab[i] = 0;
            end
        endfunction

        function void report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endfunction

        function void write_reg(t_cfg_idx idx, int v);
            case (idx)
                CFG_COORD: coord = v & 'h1f;
                CFG_OFFS:  offs  = v & 'hff;
                CFG_TCYC:  tcyc  = v & 'hff;
                CFG_CMASK: cmask = v & 'hffff;
                CFG_IMASK: imask = v & 'hffff;
                default: ;
            endcase
        endfunction

        function bit good_phase(int p);
            return p >= 1 && p <= PHASES;
        endfunction

        function bit good_ring(int r);
            return r >= 1 && r <= RINGS;
        endfunction

        function bit flag_of(int mask, int p);
            return (p >= 1 && p <= 32) ? mask[p - 1] : 1'b0;
        endfunction

        function int clamp8(int v);
            return (v < 0) ? 0 : ((v > 255) ? 255 : v);
        endfunction

        function int pass_time(int c);
            int r, sum, p;
            r = ring_tab[c - 1];
            sum = 0;
            if (!good_ring(r)) return 0;
            for (int i = 0; i < PHASES; i++) begin
                p = seq_tab[r - 1][i];
                if (!good_phase(p)) break;
                sum += split_tab[p - 1];
                if (p == c) break;
            end
            return sum;
        endfunction

        function int correction(int gap, int offset);
            int cyc, excess, t, total, cl;
            cyc = cycle_time;
            excess = gap % cyc - offset % cyc;
            t = 0;
            if (excess == 0 || excess == 1) begin
                cycles_left = 0;
            end else if (excess > 1 && excess <= SHORT_LIMIT) begin
                cycles_left = 0;
                t = -excess;
            end else begin
                total = (excess > 0) ? (cyc - excess) : -excess;
                if (cycles_left == 0) cycles_left = (tcyc == 0) ? 1 : tcyc;
                cl = cycles_left;
                t = (total <= cl || total <= SHORT_LIMIT) ? total : total / cl;
                cycles_left = (cycles_left - 1) & 'hff;
            end
            if (cyc + t > MAX_CYCLE) begin
                t = MAX_CYCLE - cyc;
                cycles_left = (cycles_left + 1) & 'hff;
            end
            return t;
        endfunction

        function int ring_search(int ring, int start_t);
            int sum, p;
            sum = 0;
            p = 0;
            for (int i = 0; i < PHASES; i++) begin
                p = seq_tab[ring][i];
                if (!good_phase(p)) return 0;
                sum += split_tab[p - 1];
                if (sum > start_t) break;
            end
            return p;
        endfunction

        function void adjust_phases(int c, int t, int start_t);
            int chosen[RINGS];
            int r, p, pr;
            r = ring_tab[c - 1];
            if (!good_ring(r)) return;
            foreach (chosen[i]) chosen[i] = 0;
            chosen[r - 1] = c;
            for (int i = 0; i < PHASES; i++) begin
                p = conc_tab[c - 1][i];
                if (!good_phase(p)) break;
                pr = ring_tab[p - 1];
                if (flag_of(cmask, p) && good_ring(pr)) chosen[pr - 1] = p;
            end
            for (int i = 0; i < RINGS; i++) begin
                p = (chosen[i] == 0) ? ring_search(i, start_t) : chosen[i];
                if (!good_phase(p)) continue;
                split_tab[p - 1] = clamp8(split_tab[p - 1] + t);
                green_tab[p - 1] = clamp8(green_tab[p - 1] + t);
            end
        endfunction

        function void note_request(t_req r);
            t_res e;
            int   c, t, pass, start_t, offset, pid;
            bit   applied;
            pid = r.phase_id;
            e = '0;
            case (r.operation)
                OP_SEQ: seq_tab[r.ring_index][r.position] = r.entry_phase;
                OP_PHASE: begin
                    if (good_phase(pid)) begin
                        split_tab[pid - 1] = r.split_value;
                        green_tab[pid - 1] = r.green_value;
                        ring_tab[pid - 1]  = r.phase_ring;
                    end
                end
                OP_CONC: if (good_phase(pid)) conc_tab[pid - 1][r.position] = r.entry_phase;
                OP_CYCLE: cycle_time = r.cycle_value;
                OP_EVAL: begin
                    c = coord;
                    t = 0;
                    applied = 0;
                    pass = good_phase(c) ? pass_time(c) : 0;
                    if (good_phase(c) && pass > 0 && !flag_of(imask, c)) begin
                        start_t = pass - split_tab[c - 1];
                        offset = offs;
                        applied = 1;
                        if (start_t > 0) offset += cycle_time - start_t;
                        if (cycle_time != 0) begin
                            t = correction(int'(r.time_gap), offset);
                            if (t != 0) begin
                                cycle_time = clamp8(cycle_time + t);
                                adjust_phases(c, t, start_t);
                            end
                        end
                    end
                    e.transition_time = t[8:0];
                    e.new_cycle = cycle_time[7:0];
                    e.was_applied = applied;
                    pending.push_back(e);
                end
                OP_READ: begin
                    e.new_cycle = cycle_time[7:0];
                    if (good_phase(pid)) begin
                        e.read_split = split_tab[pid - 1][7:0];
                        e.read_green = green_tab[pid - 1][7:0];
                    end
                    pending.push_back(e);
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_res got);
            t_res e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result %p", got));
                return;
            end
            e = pending.pop_front();
            if (got.transition_time !== e.transition_time)
                report($sformatf("transition_time %0d, expected %0d",
                                 got.transition_time, e.transition_time));
            if (got.new_cycle !== e.new_cycle)
                report($sformatf("new_cycle %0d, expected %0d", got.new_cycle, e.new_cycle));
            if (got.read_split !== e.read_split)
                report($sformatf("read_split %0d, expected %0d", got.read_split, e.read_split));
            if (got.read_green !== e.read_green)
                report($sformatf("read_green %0d, expected %0d", got.read_green, e.read_green));
            if (got.was_applied !== e.was_applied)
                report($sformatf("was_applied %0b, expected %0b",
                                 got.was_applied, e.was_applied));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_req_valid = 1'b0;
    logic        o_req_stall;
    t_req        i_req_data = '0;
    logic        o_res_valid;
    logic        i_res_stall = 1'b0;
    t_res        o_res_data;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;

    offset_scoreboard sb = new();
    bit calm = 1'b0;
    bit hold_req = 1'b0;
    int cycle_count = 0;

    signal_offset_transition i_dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_res_valid && !i_res_stall) sb.check_result(o_res_data);
            if (hold_req) begin
                hold_req = 1'b0;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && !calm && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 8);
            end
            if (stall_left > 0) begin
                i_res_stall <= 1'b1;
                stall_left--;
            end else begin
                i_res_stall <= 1'b0;
            end
        end
    end

    function automatic t_req any_req(logic [2:0] op);
        t_req r;
        r = t_req'(REQ_W'({$urandom, $urandom}));
        r.operation = op;
        r.time_gap = 17'($urandom_range(0, 86399));
        return r;
    endfunction

    task automatic send(t_req r);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req_data <= r;
        do @(posedge i_clk); while (o_req_stall);
        sb.note_request(r);
    endtask

    task automatic drain();
        i_req_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, int v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v[15:0];
        @(posedge i_clk);
        sb.write_reg(idx, v);
    endtask

    task automatic configure(int c, int offs, int tc, int cm, int im);
        drain();
        cfg_write(CFG_COORD, c);
        cfg_write(CFG_OFFS, offs);
        cfg_write(CFG_TCYC, tc);
        cfg_write(CFG_CMASK, cm);
        cfg_write(CFG_IMASK, im);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_op(logic [2:0] op, int pid, int pos, int ent);
        t_req r;
        r = any_req(op);
        r.phase_id = 5'(pid);
        r.position = 4'(pos);
        r.entry_phase = 5'(ent);
        send(r);
    endtask

    task automatic build_tables(bit one_ring, output int coord_pick);
        int   members[RINGS][$];
        int   rg, k, tmp, n;
        t_req r;
        coord_pick = 0;
        for (int p = 1; p <= PHASES; p++) begin
            rg = one_ring ? 1 : (($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, RINGS));
            r = any_req(OP_PHASE);
            r.phase_id = 5'(p);
            r.split_value = 8'($urandom_range(4, 40));
            r.green_value = 8'($urandom_range(0, 40));
            r.phase_ring = 3'(rg);
            send(r);
            if (rg != 0) members[rg - 1].push_back(p);
        end
        for (int g = 0; g < RINGS; g++) begin
            n = members[g].size();
            for (int i = n - 1; i > 0; i--) begin
                k = $urandom_range(0, i);
                tmp = members[g][i];
                members[g][i] = members[g][k];
                members[g][k] = tmp;
            end
            for (int i = 0; i <= n && i < PHASES; i++) begin
                r = any_req(OP_SEQ);
                r.ring_index = 2'(g);
                r.position = 4'(i);
                r.entry_phase = 5'((i < n) ? members[g][i] : 0);
                send(r);
            end
            if (n != 0 && (coord_pick == 0 || $urandom_range(0, 1) == 0))
                coord_pick = members[g][$urandom_range(0, n - 1)];
        end
        for (int p = 1; p <= PHASES; p++) begin
            n = $urandom_range(0, 2);
            for (int i = 0; i <= n; i++)
                send_op(OP_CONC, p, i, (i < n) ? $urandom_range(1, PHASES) : 0);
        end
    endtask

    task automatic run_mix(int count);
        t_req r;
        int   roll;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                r = any_req(OP_EVAL);
            end else if (roll < 78) begin
                r = any_req(OP_READ);
                r.phase_id = 5'($urandom_range(0, PHASES + 1));
            end else if (roll < 84) begin
                r = any_req(OP_CYCLE);
                case ($urandom_range(0, 9))
                    0: r.cycle_value = 8'd0;
                    1: r.cycle_value = 8'd255;
                    default: r.cycle_value = 8'($urandom_range(40, 200));
                endcase
            end else if (roll < 90) begin
                r = any_req(OP_PHASE);
                r.phase_id = 5'($urandom_range(1, PHASES));
                r.phase_ring = 3'($urandom_range(0, 5));
            end else begin
                r = any_req(3'($urandom_range(0, 7)));
                r.phase_id = 5'($urandom);
            end
            send(r);
        end
    endtask

    task automatic load_cycle(int v);
        t_req r;
        r = any_req(OP_CYCLE);
        r.cycle_value = 8'(v);
        send(r);
    endtask

    initial begin
        int   c;
        t_req r;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_op(OP_READ, 0, 0, 0);
        send_op(OP_READ, PHASES + 1, 0, 0);
        send_op(OP_READ, 31, 0, 0);
        send_op(OP_SPARE_LO, 1, 0, 0);
        send_op(OP_SPARE_HI, 31, 15, 31);
        send_op(OP_SEQ, 0, 15, 31);
        send_op(OP_CONC, 0, 3, 5);
        send_op(OP_CONC, PHASES + 1, 3, 5);
        send_op(OP_CONC, PHASES, 15, 0);
        r = any_req(OP_PHASE);
        r.phase_id = 5'(PHASES);
        r.split_value = 8'd255;
        r.green_value = 8'd255;
        r.phase_ring = 3'd7;
        send(r);
        r.phase_id = 5'd0;
        send(r);
        r.phase_id = 5'd31;
        send(r);
        send_op(OP_READ, PHASES, 0, 0);
        send_op(OP_READ, 1, 0, 0);
        load_cycle(0);
        send_op(OP_EVAL, 1, 0, 0);
        load_cycle(255);
        r = any_req(OP_EVAL);
        r.time_gap = 17'd86399;
        send(r);
        r.time_gap = 17'd0;
        send(r);

        for (int ph = 0; ph < 6; ph++) begin
            drain();
            build_tables(ph == 4, c);
            case (ph)
                0: configure(c, 0, 0, 0, 0);
                1: configure(c, 255, 255, 'hffff, 0);
                2: configure(c, $urandom_range(0, 255), $urandom_range(1, 8),
                             $urandom_range(0, 'hffff), $urandom_range(0, 'hffff));
                3: configure(31, 255, 1, 'hffff, 'hffff);
                4: configure(c, $urandom_range(0, 255), 3, $urandom_range(0, 'hffff), 0);
                default: configure(c, $urandom_range(0, 255), $urandom_range(0, 255),
                                   $urandom_range(0, 'hffff), 0);
            endcase
            load_cycle($urandom_range(60, 180));
            if (ph == 2) hold_req = 1'b1;
            if (ph == 3) begin
                run_mix(40);
                configure(0, 0, 0, 0, 0);
                run_mix(40);
                configure(c, 0, 2, 0, 1 << (c - 1));
                run_mix(40);
                configure(c, 17, 2, 0, 0);
            end
            if (ph == 5) calm = 1'b1;
            run_mix(ph == 3 ? 120 : 240);
        end

        drain();
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
